/* rtl/multichannel_biquad_filter_assert.svh */
// Assertion macros for the biquad filter bank.
// Each use expands to one labelled concurrent assertion clocked on clk and
// disabled while rst is high.
`ifndef MULTICHANNEL_BIQUAD_FILTER_ASSERT_SVH
`define MULTICHANNEL_BIQUAD_FILTER_ASSERT_SVH

// Same-cycle implication.
`define MBQ_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication.
`define MBQ_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* rtl/mbq_pkg.sv */
`timescale 1ns / 1ps

package mbq_pkg;

  localparam int DATA_W  = 32;
  localparam int CH_W    = 3;
  localparam int CFG_W   = 3;
  localparam int PROD_W  = 2 * DATA_W;
  // five full products sum to less than 2^65 in magnitude
  localparam int ACC_W   = PROD_W + 2;
  localparam int STEP_W  = 3;

  localparam logic [CFG_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_W-1:0] REG_A0 = 3'd3;
  localparam logic [CFG_W-1:0] REG_A1 = 3'd4;
  localparam logic [CFG_W-1:0] REG_A2 = 3'd5;

  // multiply-accumulate sequence: one product per step, then a drain step
  localparam logic [STEP_W-1:0] STEP_B0    = 3'd0;
  localparam logic [STEP_W-1:0] STEP_B1    = 3'd1;
  localparam logic [STEP_W-1:0] STEP_B2    = 3'd2;
  localparam logic [STEP_W-1:0] STEP_A1    = 3'd3;
  localparam logic [STEP_W-1:0] STEP_A2    = 3'd4;
  localparam logic [STEP_W-1:0] STEP_DRAIN = 3'd5;

  localparam logic signed [DATA_W-1:0] RST_B0 = 32'sh2000_0000;
  localparam logic signed [DATA_W-1:0] RST_A0 = 32'sh2000_0000;

  typedef struct packed {
    logic clear;
    logic issue;
    logic sub;
  } mac_ctrl_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x1;
    logic signed [DATA_W-1:0] x2;
    logic signed [DATA_W-1:0] y1;
    logic signed [DATA_W-1:0] y2;
  } hist_t;

  typedef struct packed {
    logic                     en;
    logic [CH_W-1:0]          ch;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
  } hist_wr_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/multichannel_biquad_filter.sv */
`timescale 1ns / 1ps

// Bank of second-order direct-form-I IIR filters sharing one coefficient set.
// Each request carries a channel and a Q16.16 sample; the result is
// (b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2) / a0 for that channel, truncated
// toward zero and saturated to 32 bits, with coefficients in Q3.29. A
// request runs five products through a single 32x32 multiplier with a drain
// step, then a step that forms magnitudes for the divider, then a
// one-bit-per-cycle restoring divider, before the result is handed over. A zero
// a0 bypasses the multiplier and divider and answers with
// divide_fault set, sample_out zero, and no history change. in_stall stays
// high while a request is in flight; a finished result sits in the output
// register so the next request can be taken while it waits. Histories of all
// channels are cleared by reset; channels at or beyond CHANNELS use zero
// histories and are never updated. Write coefficients only while idle.
module multichannel_biquad_filter
  import mbq_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CH_W-1:0]          channel,
  input  logic signed [DATA_W-1:0] sample_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CH_W-1:0]          channel_out,
  output logic signed [DATA_W-1:0] sample_out,
  output logic                     saturated,
  output logic                     divide_fault,
  input  logic                     cfg_write_en,
  input  logic [CFG_W-1:0]         cfg_index,
  input  logic [DATA_W-1:0]        cfg_data
);

`include "multichannel_biquad_filter_assert.svh"

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_NORM = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic signed [DATA_W-1:0] coeff_b0;
  logic signed [DATA_W-1:0] coeff_b1;
  logic signed [DATA_W-1:0] coeff_b2;
  logic signed [DATA_W-1:0] coeff_a0;
  logic signed [DATA_W-1:0] coeff_a1;
  logic signed [DATA_W-1:0] coeff_a2;

  logic [CH_W-1:0]          ch;
  logic signed [DATA_W-1:0] x;
  logic                     fault;
  logic [STEP_W-1:0]        step;

  logic                     in_take;
  logic                     out_take;
  logic                     out_load;

  hist_t                    hist;
  hist_wr_t                 hist_wr;
  mac_ctrl_t                mac_ctrl;
  logic signed [DATA_W-1:0] op_a;
  logic signed [DATA_W-1:0] op_b;
  logic signed [ACC_W-1:0]  acc;
  div_ctrl_t                div_ctrl;
  div_stat_t                div_stat;
  logic signed [DATA_W-1:0] div_q;
  logic                     div_sat;

  // Coefficient registers: plain write port, unknown indexes dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_b0 <= RST_B0;
      coeff_b1 <= '0;
      coeff_b2 <= '0;
      coeff_a0 <= RST_A0;
      coeff_a1 <= '0;
      coeff_a2 <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_B0:  coeff_b0 <= cfg_data;
        REG_B1:  coeff_b1 <= cfg_data;
        REG_B2:  coeff_b2 <= cfg_data;
        REG_A0:  coeff_a0 <= cfg_data;
        REG_A1:  coeff_a1 <= cfg_data;
        REG_A2:  coeff_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshakes. Take a new request only when idle; the output register
  // decouples the result from the next request.
  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          state_next = (coeff_a0 == '0) ? S_DONE : S_MUL;
        end
      end
      S_MUL: begin
        if (step == STEP_DRAIN) begin
          state_next = S_NORM;
        end
      end
      S_NORM: state_next = S_DIV;
      S_DIV: begin
        if (div_stat.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      fault <= 1'b0;
    end else begin
      state <= state_next;
      if (in_take) begin
        step  <= STEP_B0;
        fault <= (coeff_a0 == '0);
      end else if (state == S_MUL) begin
        step <= step + 1'b1;
      end
    end
  end

  // Hold the request for the whole computation.
  always_ff @(posedge clk) begin
    if (in_take) begin
      ch <= channel;
      x  <= sample_in;
    end
  end

  // Operand selection for the shared multiplier; feedback terms subtract.
  always_comb begin
    mac_ctrl.clear = in_take;
    mac_ctrl.issue = 1'b0;
    mac_ctrl.sub   = 1'b0;
    op_a           = coeff_b0;
    op_b           = x;
    if (state == S_MUL) begin
      case (step)
        STEP_B0: begin
          mac_ctrl.issue = 1'b1;
        end
        STEP_B1: begin
          mac_ctrl.issue = 1'b1;
          op_a           = coeff_b1;
          op_b           = hist.x1;
        end
        STEP_B2: begin
          mac_ctrl.issue = 1'b1;
          op_a           = coeff_b2;
          op_b           = hist.x2;
        end
        STEP_A1: begin
          mac_ctrl.issue = 1'b1;
          mac_ctrl.sub   = 1'b1;
          op_a           = coeff_a1;
          op_b           = hist.y1;
        end
        STEP_A2: begin
          mac_ctrl.issue = 1'b1;
          mac_ctrl.sub   = 1'b1;
          op_a           = coeff_a2;
          op_b           = hist.y2;
        end
        default: ;
      endcase
    end
  end

  assign div_ctrl.start = (state == S_NORM);

  // Shift the channel's history as the result is handed over; skip on fault.
  assign hist_wr.en = out_load && !fault;
  assign hist_wr.ch = ch;
  assign hist_wr.x  = x;
  assign hist_wr.y  = div_q;

  mbq_hist #(
    .CHANNELS (CHANNELS)
  ) u_hist (
    .clk   (clk),
    .rst   (rst),
    .rd_ch (ch),
    .rd    (hist),
    .wr    (hist_wr)
  );

  mbq_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  mbq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (acc),
    .divisor  (coeff_a0),
    .stat     (div_stat),
    .quotient (div_q),
    .sat      (div_sat)
  );

  // Output register: load on completion, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      channel_out  <= ch;
      sample_out   <= fault ? '0 : div_q;
      saturated    <= fault ? 1'b0 : div_sat;
      divide_fault <= fault;
    end
  end

  // A faulted result always carries a zero, unclipped sample.
  `MBQ_ASSERT_NOW(a_fault_zero, out_valid && divide_fault, (sample_out == '0) && !saturated,
                  "divide fault with non-zero sample")
  // The divider only finishes while the sequencer waits for it.
  `MBQ_ASSERT_NOW(a_div_done_state, div_stat.done, state == S_DIV,
                  "divider finished outside the divide phase")
  // History moves only with a non-faulted result entering the output register.
  `MBQ_ASSERT_NOW(a_hist_write, hist_wr.en, (state == S_DONE) && !fault,
                  "history written outside result hand-over")
  // An accepted request leaves the idle state on the next cycle.
  `MBQ_ASSERT_NEXT(a_accept_busy, in_take, state != S_IDLE,
                   "request accepted but sequencer still idle")

endmodule

/* rtl/mbq_hist.sv */
`timescale 1ns / 1ps

module mbq_hist
  import mbq_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [CH_W-1:0] rd_ch,
  output hist_t           rd,
  input  hist_wr_t        wr
);

  // only channels the 3-bit index can reach need storage
  localparam int DEPTH = (CHANNELS < (1 << CH_W)) ? CHANNELS : (1 << CH_W);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CH_W:0] DEPTH_L = (CH_W + 1)'(DEPTH);

  hist_t mem [DEPTH];

  logic rd_ok;
  logic wr_ok;

  assign rd_ok = {1'b0, rd_ch} < DEPTH_L;
  assign wr_ok = {1'b0, wr.ch} < DEPTH_L;

  // channels outside the bank see an all-zero history
  always_comb begin
    rd = '0;
    if (rd_ok) begin
      rd = mem[rd_ch[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        mem[i] <= '0;
      end
    end else if (wr.en && wr_ok) begin
      mem[wr.ch[IDX_W-1:0]].x2 <= mem[wr.ch[IDX_W-1:0]].x1;
      mem[wr.ch[IDX_W-1:0]].x1 <= wr.x;
      mem[wr.ch[IDX_W-1:0]].y2 <= mem[wr.ch[IDX_W-1:0]].y1;
      mem[wr.ch[IDX_W-1:0]].y1 <= wr.y;
    end
  end

endmodule

/* rtl/mbq_mac.sv */
`timescale 1ns / 1ps

module mbq_mac
  import mbq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctrl_t                ctrl,
  input  logic signed [DATA_W-1:0] op_a,
  input  logic signed [DATA_W-1:0] op_b,
  output logic signed [ACC_W-1:0]  acc
);

  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;
  logic                     prod_sub;
  logic signed [ACC_W-1:0]  prod_ext;

  assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};

  // register the product, accumulate it on the next cycle
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      prod_sub <= 1'b0;
      acc      <= '0;
    end else if (ctrl.clear) begin
      prod_vld <= 1'b0;
      prod_sub <= 1'b0;
      acc      <= '0;
    end else begin
      prod_vld <= ctrl.issue;
      prod_sub <= ctrl.sub;
      if (prod_vld) begin
        acc <= prod_sub ? (acc - prod_ext) : (acc + prod_ext);
      end
    end
  end

endmodule

/* rtl/mbq_div.sv */
`timescale 1ns / 1ps

module mbq_div
  import mbq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  div_ctrl_t                ctrl,
  input  logic signed [ACC_W-1:0]  dividend,
  input  logic signed [DATA_W-1:0] divisor,
  output div_stat_t                stat,
  output logic signed [DATA_W-1:0] quotient,
  output logic                     sat
);

  localparam int CNT_W = $clog2(DATA_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);
  localparam logic [DATA_W-1:0] NEG_LIMIT = {1'b1, {(DATA_W - 1){1'b0}}};
  localparam logic [DATA_W-1:0] POS_LIMIT = {1'b0, {(DATA_W - 1){1'b1}}};

  logic [ACC_W-1:0]  mag_n;
  logic [DATA_W-1:0] mag_d;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              take;

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dsr;
  logic              neg;
  logic              ovf;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  assign mag_n = dividend[ACC_W-1] ? (~dividend + 1'b1) : dividend;
  assign mag_d = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;

  // one restoring step per cycle
  assign trial = {rem, quo[DATA_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign take  = !diff[DATA_W];

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= mag_n[2*DATA_W-1:DATA_W];
      quo <= mag_n[DATA_W-1:0];
      dsr <= mag_d;
      neg <= dividend[ACC_W-1] ^ divisor[DATA_W-1];
      // quotient of 2^32 or more whenever the upper part reaches the divisor
      ovf <= mag_n[ACC_W-2:DATA_W] >= {1'b0, mag_d};
    end else if (busy) begin
      rem <= take ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo <= {quo[DATA_W-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_LAST);
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

  // clip to the signed 32-bit range, truncating toward zero
  always_comb begin
    if (neg) begin
      sat      = ovf || (quo > NEG_LIMIT);
      quotient = sat ? NEG_LIMIT : (~quo + 1'b1);
    end else begin
      sat      = ovf || quo[DATA_W-1];
      quotient = sat ? POS_LIMIT : quo;
    end
  end

endmodule

/* tb/biquad_result_checker.sv */
`timescale 1ns / 1ps

module biquad_result_checker
  import mbq_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [CH_W-1:0]          channel,
  input  logic signed [DATA_W-1:0] sample_in,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [CH_W-1:0]          channel_out,
  input  logic signed [DATA_W-1:0] sample_out,
  input  logic                     saturated,
  input  logic                     divide_fault,
  input  logic                     cfg_write_en,
  input  logic [CFG_W-1:0]         cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  output int                       fail_count,
  output int                       pending
);

  localparam logic signed [127:0] Q_MAX = 128'sd2147483647;
  localparam logic signed [127:0] Q_MIN = -128'sd2147483648;

  typedef struct packed {
    logic [CH_W-1:0]          ch;
    logic signed [DATA_W-1:0] sample;
    logic                     sat;
    logic                     fault;
  } filter_result_t;

  logic signed [DATA_W-1:0] b0, b1, b2, a0, a1, a2;
  logic signed [DATA_W-1:0] x_hist1 [CHANNELS];
  logic signed [DATA_W-1:0] x_hist2 [CHANNELS];
  logic signed [DATA_W-1:0] y_hist1 [CHANNELS];
  logic signed [DATA_W-1:0] y_hist2 [CHANNELS];

  filter_result_t awaited_results [$];
  filter_result_t oldest;

  // One step on the bank copy; updates the channel history unless a0 is zero.
  function automatic filter_result_t filter_step(input logic [CH_W-1:0] ch,
                                                 input logic signed [DATA_W-1:0] x);
    logic signed [DATA_W-1:0] x1, x2, y1, y2;
    logic signed [127:0] acc, divisor, quot;
    logic in_bank;
    filter_result_t r;
    in_bank  = (int'(ch) < CHANNELS);
    r.ch     = ch;
    r.sample = '0;
    r.sat    = 1'b0;
    r.fault  = 1'b0;
    x1 = '0;
    x2 = '0;
    y1 = '0;
    y2 = '0;
    if (a0 == 0) begin
      r.fault = 1'b1;
      return r;
    end
    if (in_bank) begin
      x1 = x_hist1[ch];
      x2 = x_hist2[ch];
      y1 = y_hist1[ch];
      y2 = y_hist2[ch];
    end
    // all operands widen to 128 bits, so the sum is exact
    acc     = b0 * x + b1 * x1 + b2 * x2 - a1 * y1 - a2 * y2;
    divisor = a0;
    quot    = acc / divisor;
    if (quot > Q_MAX) begin
      r.sat    = 1'b1;
      r.sample = 32'sh7FFF_FFFF;
    end else if (quot < Q_MIN) begin
      r.sat    = 1'b1;
      r.sample = 32'sh8000_0000;
    end else begin
      r.sample = quot[DATA_W-1:0];
    end
    if (in_bank) begin
      x_hist2[ch] = x1;
      x_hist1[ch] = x;
      y_hist2[ch] = y1;
      y_hist1[ch] = r.sample;
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      b0 = RST_B0;
      b1 = '0;
      b2 = '0;
      a0 = RST_A0;
      a1 = '0;
      a2 = '0;
      for (int i = 0; i < CHANNELS; i++) begin
        x_hist1[i] = '0;
        x_hist2[i] = '0;
        y_hist1[i] = '0;
        y_hist2[i] = '0;
      end
      awaited_results.delete();
      fail_count = 0;
    end else begin
      // results first: one leaving now belongs to an earlier request
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding: channel_out %0d sample_out %h",
                 channel_out, sample_out);
          fail_count++;
        end else begin
          oldest = awaited_results.pop_front();
          compare_field("channel_out", DATA_W'(oldest.ch), DATA_W'(channel_out));
          compare_field("sample_out", oldest.sample, sample_out);
          compare_field("saturated", DATA_W'(oldest.sat), DATA_W'(saturated));
          compare_field("divide_fault", DATA_W'(oldest.fault), DATA_W'(divide_fault));
        end
      end
      if (in_valid && !in_stall)
        awaited_results.insert(awaited_results.size(), filter_step(channel, sample_in));
      if (cfg_write_en) begin
        case (cfg_index)
          REG_B0: b0 = cfg_data;
          REG_B1: b1 = cfg_data;
          REG_B2: b2 = cfg_data;
          REG_A0: a0 = cfg_data;
          REG_A1: a1 = cfg_data;
          REG_A2: a2 = cfg_data;
          default: ;
        endcase
      end
    end
    pending = awaited_results.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import mbq_pkg::*;

  localparam int CHANNELS       = 8;
  // indexes past the register list; writes there must be ignored
  localparam logic [CFG_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int RANDOM_PER_SET = 144;
  localparam int SETS_PER_MODE  = 4;
  // leave margin after the last result before writing registers
  localparam int SETTLE_CYCLES  = 4;
  localparam int END_SETTLE     = 60;
  // the limit lies beyond any honest gap between two accepted requests or
  // results, so this only fires on a hang
  localparam int WATCHDOG_LIMIT = 2000;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [CH_W-1:0]          channel;
  logic signed [DATA_W-1:0] sample_in;
  logic                     out_valid;
  logic                     out_stall;
  logic [CH_W-1:0]          channel_out;
  logic signed [DATA_W-1:0] sample_out;
  logic                     saturated;
  logic                     divide_fault;
  logic                     cfg_write_en;
  logic [CFG_W-1:0]         cfg_index;
  logic [DATA_W-1:0]        cfg_data;

  int fail_count;
  int pending;
  int in_idle_pct  = 17;
  int out_idle_pct = 62;
  int idle_cycles;

  multichannel_biquad_filter #(
    .CHANNELS(CHANNELS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .channel     (channel),
    .sample_in   (sample_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .channel_out (channel_out),
    .sample_out  (sample_out),
    .saturated   (saturated),
    .divide_fault(divide_fault),
    .cfg_write_en(cfg_write_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  biquad_result_checker #(
    .CHANNELS(CHANNELS)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .channel     (channel),
    .sample_in   (sample_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .channel_out (channel_out),
    .sample_out  (sample_out),
    .saturated   (saturated),
    .divide_fault(divide_fault),
    .cfg_write_en(cfg_write_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: decide the stall for the coming edge on each falling edge.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(0, 99) < out_idle_pct);
    end
  end

  // Watchdog: count edges at which neither a request nor a result moves.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Present one request and hold it until the block takes it. Idle cycles
  // before it carry junk payload with valid low.
  task automatic drive_request(input logic [CH_W-1:0] ch, input logic [DATA_W-1:0] x);
    @(negedge clk);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid  = 1'b0;
      channel   = CH_W'($urandom);
      sample_in = $urandom;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    channel   = ch;
    sample_in = x;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and hold off until every outstanding result has been taken.
  task automatic hold_until_drained(input int settle);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_write_en = 1'b1;
    cfg_index    = idx;
    cfg_data     = val;
  endtask

  // Load a full coefficient set; also poke the spare indexes with junk.
  task automatic write_coeffs(input logic [DATA_W-1:0] b0, input logic [DATA_W-1:0] b1,
                              input logic [DATA_W-1:0] b2, input logic [DATA_W-1:0] a0,
                              input logic [DATA_W-1:0] a1, input logic [DATA_W-1:0] a2);
    put_reg(REG_SPARE_LO, $urandom);
    put_reg(REG_B0, b0);
    put_reg(REG_B1, b1);
    put_reg(REG_B2, b2);
    put_reg(REG_A0, a0);
    put_reg(REG_A1, a1);
    put_reg(REG_A2, a2);
    put_reg(REG_SPARE_HI, $urandom);
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  // Mostly moderate samples so the recursion stays in range, with extremes
  // and full-width noise mixed in.
  function automatic logic [DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom;
      default: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    endcase
  endfunction

  // Coefficients mostly within +/-1.0, sometimes at the rails or anywhere.
  function automatic logic [DATA_W-1:0] pick_coeff();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom;
      3:       return '0;
      default: return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
    endcase
  endfunction

  // Divisor near +1.0 most of the time; zero now and then to hit the fault path.
  function automatic logic [DATA_W-1:0] pick_divisor();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return 32'h8000_0000;
      2:       return $urandom;
      3:       return 32'h0000_0001;
      4:       return 32'hE000_0000;
      default: return 32'h2000_0000 + $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
    endcase
  endfunction

  task automatic run_random_batch(input int count);
    for (int n = 0; n < count; n++) begin
      drive_request(CH_W'($urandom_range(0, CHANNELS - 1)), pick_sample());
      // now and then starve the block completely before going on
      if ($urandom_range(0, 249) == 0)
        hold_until_drained(SETTLE_CYCLES);
    end
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    channel      = '0;
    sample_in    = '0;
    cfg_write_en = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset coefficients give a unity filter: push the sample extremes through.
    drive_request(3'd0, 32'h7FFF_FFFF);
    drive_request(3'd7, 32'h8000_0000);
    drive_request(3'd1, 32'h0000_0000);
    drive_request(3'd2, 32'hFFFF_FFFF);
    drive_request(3'd3, 32'h0000_0001);

    // Largest gains over the smallest divisor: saturate both ways.
    hold_until_drained(SETTLE_CYCLES);
    write_coeffs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF);
    drive_request(3'd0, 32'h7FFF_FFFF);
    drive_request(3'd0, 32'h8000_0000);
    drive_request(3'd4, 32'h0000_0001);
    drive_request(3'd4, 32'h0000_0000);

    // Zero divisor: results forced to zero, histories must stay put.
    hold_until_drained(SETTLE_CYCLES);
    write_coeffs(32'h2000_0000, 32'h1000_0000, 32'hF000_0000, 32'h0, 32'h0, 32'h0);
    drive_request(3'd0, 32'h1234_5678);
    drive_request(3'd7, 32'h8000_0000);
    drive_request(3'd3, 32'h7FFF_FFFF);

    // Most negative divisor with feedback, reading the histories left above.
    hold_until_drained(SETTLE_CYCLES);
    write_coeffs(32'h8000_0000, 32'h2000_0000, 32'hE000_0000,
                 32'h8000_0000, 32'h2000_0000, 32'hE000_0000);
    drive_request(3'd0, 32'h0001_0000);
    drive_request(3'd0, 32'h8000_0000);
    drive_request(3'd7, 32'h7FFF_FFFF);
    drive_request(3'd3, 32'hFFFF_0000);

    // Largest positive divisor.
    hold_until_drained(SETTLE_CYCLES);
    write_coeffs(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    drive_request(3'd5, 32'h7FFF_FFFF);
    drive_request(3'd5, 32'h8000_0000);
    drive_request(3'd6, 32'h5A5A_5A5A);

    // Random part: sender-light, then receiver-light, then no idling at all.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          in_idle_pct  = 17;
          out_idle_pct = 62;
        end
        1: begin
          in_idle_pct  = 62;
          out_idle_pct = 17;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      for (int set = 0; set < SETS_PER_MODE; set++) begin
        hold_until_drained(SETTLE_CYCLES);
        write_coeffs(pick_coeff(), pick_coeff(), pick_coeff(),
                     pick_divisor(), pick_coeff(), pick_coeff());
        run_random_batch(RANDOM_PER_SET);
      end
    end

    hold_until_drained(END_SETTLE);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
